@@ rtl/mvt_pkg.sv @@
// Shared types and constants of the 4x4 matrix-vector transform.
package mvt_pkg;

   localparam int NUM_REGS      = 8;
   localparam int REG_IDX_W     = 4;
   localparam int REG_W         = 64;
   localparam int ELEM_W        = 32;
   localparam int DEF_ROW_DOT   = 0;
   localparam int DEF_FRAC_BITS = 16;

   typedef logic signed [ELEM_W-1:0]     elem_type;
   typedef elem_type [3:0]               vec_type;
   typedef elem_type [3:0][3:0]          mat_type;

   typedef logic signed [2*ELEM_W-1:0]   prod_type;
   typedef prod_type [3:0][3:0]          prod_mat_type;

   typedef logic signed [2*ELEM_W:0]     psum_type;
   typedef psum_type [3:0][1:0]          psum_mat_type;

   typedef logic signed [2*ELEM_W+1:0]   sum_type;
   typedef sum_type [3:0]                sum_vec_type;

endpackage

@@ rtl/mvt_csr.sv @@
// Matrix register file written through the configuration channel.
module mvt_csr #(
   parameter int FRAC_BITS = mvt_pkg::DEF_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mvt_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [mvt_pkg::REG_W-1:0]      csr_data,
   output mvt_pkg::mat_type               mat
);

   localparam mvt_pkg::elem_type ONE_FIX = mvt_pkg::elem_type'(1) << FRAC_BITS;

   mvt_pkg::mat_type mat_ff;
   mvt_pkg::mat_type mat_in;
   logic [1:0]       row;
   logic [1:0]       col_lo;

   assign csr_ready = 1'b1;
   assign row       = csr_index[2:1];
   assign col_lo    = {csr_index[0], 1'b0};

   always_comb begin
      mat_in = mat_ff;
      // indexes past the last register are dropped
      if (csr_valid && (csr_index < mvt_pkg::REG_IDX_W'(mvt_pkg::NUM_REGS))) begin
         mat_in[row][col_lo]        = csr_data[31:0];
         mat_in[row][col_lo + 2'd1] = csr_data[63:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               mat_ff[r][c] <= (r == c) ? ONE_FIX : '0;
            end
         end
      end else begin
         mat_ff <= mat_in;
      end
   end

   assign mat = mat_ff;

endmodule

@@ rtl/mvt_mul.sv @@
// Product stage: sixteen 32x32 signed products, registered.
module mvt_mul #(
   parameter int ROW_DOT = mvt_pkg::DEF_ROW_DOT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mvt_pkg::vec_type      vec,
   input  mvt_pkg::mat_type      mat,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mvt_pkg::prod_mat_type prod
);

   logic                  valid_ff;
   logic                  valid_in;
   mvt_pkg::prod_mat_type prod_ff;
   mvt_pkg::prod_mat_type prod_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int t = 0; t < 4; t++) begin
            // column dot by default, row dot for the GL convention
            prod_in[k][t] = $signed(vec[t]) *
                            $signed((ROW_DOT != 0) ? mat[k][t] : mat[t][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign prod      = prod_ff;

endmodule

@@ rtl/mvt_acc.sv @@
// Adder tree: pair sums in one stage, full 66-bit sums in the next.
module mvt_acc (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mvt_pkg::prod_mat_type prod,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mvt_pkg::sum_vec_type  sum
);

   logic                  pair_valid_ff;
   logic                  pair_valid_in;
   logic                  pair_ready;
   mvt_pkg::psum_mat_type pair_ff;
   mvt_pkg::psum_mat_type pair_in;
   logic                  sum_valid_ff;
   logic                  sum_valid_in;
   mvt_pkg::sum_vec_type  sum_ff;
   mvt_pkg::sum_vec_type  sum_in;

   assign pair_ready    = !sum_valid_ff || out_ready;
   assign in_ready      = !pair_valid_ff || pair_ready;
   assign pair_valid_in = in_ready ? in_valid : pair_valid_ff;
   assign sum_valid_in  = pair_ready ? pair_valid_ff : sum_valid_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pair_in[k][0] = mvt_pkg::psum_type'($signed(prod[k][0])) +
                         mvt_pkg::psum_type'($signed(prod[k][1]));
         pair_in[k][1] = mvt_pkg::psum_type'($signed(prod[k][2])) +
                         mvt_pkg::psum_type'($signed(prod[k][3]));
         sum_in[k]     = mvt_pkg::sum_type'($signed(pair_ff[k][0])) +
                         mvt_pkg::sum_type'($signed(pair_ff[k][1]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         pair_valid_ff <= pair_valid_in;
         sum_valid_ff  <= sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         pair_ff <= pair_in;
      end
      if (pair_ready) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign sum       = sum_ff;

endmodule

@@ rtl/mvt_sat.sv @@
// Output stage: floor shift by the fraction width and clamp to 32 bits.
module mvt_sat #(
   parameter int FRAC_BITS = mvt_pkg::DEF_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  mvt_pkg::sum_vec_type sum,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mvt_pkg::vec_type     res
);

   localparam mvt_pkg::sum_type MAX_VAL =
      mvt_pkg::sum_type'({1'b0, {(mvt_pkg::ELEM_W-1){1'b1}}});
   localparam mvt_pkg::sum_type MIN_VAL = -MAX_VAL - mvt_pkg::sum_type'(1);

   logic             valid_ff;
   logic             valid_in;
   mvt_pkg::vec_type res_ff;
   mvt_pkg::vec_type res_in;
   mvt_pkg::sum_type shifted;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      shifted = '0;
      for (int k = 0; k < 4; k++) begin
         // arithmetic shift rounds toward minus infinity
         shifted = $signed(sum[k]) >>> FRAC_BITS;
         if (shifted > MAX_VAL) begin
            res_in[k] = MAX_VAL[mvt_pkg::ELEM_W-1:0];
         end else if (shifted < MIN_VAL) begin
            res_in[k] = MIN_VAL[mvt_pkg::ELEM_W-1:0];
         end else begin
            res_in[k] = shifted[mvt_pkg::ELEM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = valid_ff;
   assign res       = res_ff;

endmodule

@@ rtl/matrix4_vector_transform.sv @@
// Top level of the 4x4 matrix times 4-vector transform unit.
//
// Requests carry one vector (req_vec_x..w, signed fixed point with FRAC_BITS
// fraction bits) on a valid/ready channel; each request gives exactly one
// result vector on the rsp_ channel, in order. With ROW_DOT = 0 result k is
// the vector dotted with matrix column k, with ROW_DOT = 1 with row k.
// The matrix lives in eight 64-bit registers written on the csr_ channel
// (index 0..7, two elements per register, low half first); csr_ready is
// always high and indexes past 7 are dropped. Write only while idle.
// Pipeline: four register stages (multiply, pair add, final add, shift and
// clamp). Throughput: one request per cycle while rsp_ready stays high, set
// by the four register stages, each of which moves whenever the stage after
// it is empty or moving. When rsp_ready is low, results back up stage by
// stage and req_ready drops only once all four stages are full; nothing is
// lost or repeated.
// Reset empties the pipeline and loads the identity matrix.
module matrix4_vector_transform #(
   parameter int ROW_DOT   = mvt_pkg::DEF_ROW_DOT,
   parameter int FRAC_BITS = mvt_pkg::DEF_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [31:0]             req_vec_x,
   input  logic signed [31:0]             req_vec_y,
   input  logic signed [31:0]             req_vec_z,
   input  logic signed [31:0]             req_vec_w,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [31:0]             rsp_out_x,
   output logic signed [31:0]             rsp_out_y,
   output logic signed [31:0]             rsp_out_z,
   output logic signed [31:0]             rsp_out_w,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mvt_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [mvt_pkg::REG_W-1:0]      csr_data
);

   mvt_pkg::vec_type      vec;
   mvt_pkg::mat_type      mat;
   mvt_pkg::prod_mat_type prod;
   mvt_pkg::sum_vec_type  sum;
   mvt_pkg::vec_type      res;
   logic                  mul_valid;
   logic                  mul_ready;
   logic                  acc_valid;
   logic                  acc_ready;

   assign vec[0] = req_vec_x;
   assign vec[1] = req_vec_y;
   assign vec[2] = req_vec_z;
   assign vec[3] = req_vec_w;

   mvt_csr #(
      .FRAC_BITS (FRAC_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .mat       (mat)
   );

   mvt_mul #(
      .ROW_DOT (ROW_DOT)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .vec       (vec),
      .mat       (mat),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .prod      (prod)
   );

   mvt_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (mul_ready),
      .prod      (prod),
      .out_valid (acc_valid),
      .out_ready (acc_ready),
      .sum       (sum)
   );

   mvt_sat #(
      .FRAC_BITS (FRAC_BITS)
   ) u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc_valid),
      .in_ready  (acc_ready),
      .sum       (sum),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .res       (res)
   );

   assign rsp_out_x = res[0];
   assign rsp_out_y = res[1];
   assign rsp_out_z = res[2];
   assign rsp_out_w = res[3];

endmodule

@@ bench/mvt_checker.sv @@
// Scoreboard for the matrix-vector transform: mirrors the matrix, predicts and checks results.
`timescale 1ns / 100ps

module mvt_checker #(
   parameter int ROW_DOT   = mvt_pkg::DEF_ROW_DOT,
   parameter int FRAC_BITS = mvt_pkg::DEF_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic signed [31:0]             req_vec_x,
   input  logic signed [31:0]             req_vec_y,
   input  logic signed [31:0]             req_vec_z,
   input  logic signed [31:0]             req_vec_w,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic signed [31:0]             rsp_out_x,
   input  logic signed [31:0]             rsp_out_y,
   input  logic signed [31:0]             rsp_out_z,
   input  logic signed [31:0]             rsp_out_w,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [mvt_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [mvt_pkg::REG_W-1:0]      csr_data,
   output int                             fail_count,
   output int                             outstanding
);

   localparam mvt_pkg::elem_type ELEM_MAX = 32'sh7FFF_FFFF;
   localparam mvt_pkg::elem_type ELEM_MIN = 32'sh8000_0000;
   localparam int                EW       = mvt_pkg::ELEM_W;

   mvt_pkg::mat_type matrix_copy;
   mvt_pkg::vec_type result_q[$];
   string            lane_name[4] = '{"x", "y", "z", "w"};

   function automatic mvt_pkg::mat_type identity_matrix();
      mvt_pkg::mat_type m;
      int r, c;
      for (r = 0; r < 4; r++)
         for (c = 0; c < 4; c++)
            m[r][c] = (r == c) ? mvt_pkg::elem_type'(1 << FRAC_BITS) : '0;
      return m;
   endfunction

   // full-width sum of four products, floor shift, clamp to 32 bits
   function automatic mvt_pkg::vec_type transform(input mvt_pkg::vec_type v,
                                                  input mvt_pkg::mat_type m);
      mvt_pkg::vec_type  r;
      mvt_pkg::prod_type p;
      mvt_pkg::sum_type  acc;
      mvt_pkg::sum_type  shifted;
      int k, t;
      for (k = 0; k < 4; k++) begin
         acc = '0;
         for (t = 0; t < 4; t++) begin
            if (ROW_DOT != 0)
               p = $signed(v[t]) * $signed(m[k][t]);
            else
               p = $signed(v[t]) * $signed(m[t][k]);
            acc = acc + {{2{p[2*EW-1]}}, p};
         end
         shifted = acc >>> FRAC_BITS;
         if (shifted[2*EW+1:EW-1] != {(EW+3){shifted[2*EW+1]}})
            r[k] = shifted[2*EW+1] ? ELEM_MIN : ELEM_MAX;
         else
            r[k] = shifted[EW-1:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin : track
      mvt_pkg::vec_type vin;
      mvt_pkg::vec_type got;
      mvt_pkg::vec_type want;
      int errs;
      int k;
      errs = 0;
      if (reset) begin
         matrix_copy = identity_matrix();
         result_q.delete();
      end else begin
         if (csr_valid && csr_ready && csr_index < mvt_pkg::NUM_REGS) begin
            matrix_copy[csr_index / 2][(csr_index % 2) * 2]     = csr_data[31:0];
            matrix_copy[csr_index / 2][(csr_index % 2) * 2 + 1] = csr_data[63:32];
         end
         if (req_valid && req_ready) begin
            vin = {req_vec_w, req_vec_z, req_vec_y, req_vec_x};
            result_q.push_back(transform(vin, matrix_copy));
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_w, rsp_out_z, rsp_out_y, rsp_out_x};
            if (result_q.size() == 0) begin
               $display("%0t: result with no request pending, expected none actual %h",
                        $time, got);
               errs++;
            end else begin
               want = result_q.pop_front();
               for (k = 0; k < 4; k++)
                  if (got[k] !== want[k]) begin
                     $display("%0t: out_%s mismatch, expected %h actual %h",
                              $time, lane_name[k], want[k], got[k]);
                     errs++;
                  end
            end
         end
      end
      fail_count  <= fail_count + errs;
      outstanding <= result_q.size();
   end

endmodule

@@ bench/tb_matrix4_vector_transform.sv @@
// Testbench top for the matrix-vector transform: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_matrix4_vector_transform;

   localparam int ROW_DOT_SEL = 0;
   localparam int FRAC_SEL    = 16;
   localparam int LONG_HOLD   = 64;
   localparam int PHASE_ITEMS = 107;
   localparam int IW          = mvt_pkg::REG_IDX_W;

   localparam mvt_pkg::elem_type ELEM_MAX = 32'sh7FFF_FFFF;
   localparam mvt_pkg::elem_type ELEM_MIN = 32'sh8000_0000;
   localparam mvt_pkg::elem_type ONE      = mvt_pkg::elem_type'(1 << FRAC_SEL);

   typedef enum int {FILL_FULL, FILL_SMALL, FILL_EDGE, FILL_MIXED,
                     FILL_IDENT, FILL_ZERO} fill_mode_type;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic signed [31:0]            req_vec_x = '0;
   logic signed [31:0]            req_vec_y = '0;
   logic signed [31:0]            req_vec_z = '0;
   logic signed [31:0]            req_vec_w = '0;
   logic                          rsp_ready = 1'b0;
   logic                          csr_valid = 1'b0;
   logic [mvt_pkg::REG_IDX_W-1:0] csr_index = '0;
   logic [mvt_pkg::REG_W-1:0]     csr_data  = '0;

   logic                  req_ready;
   logic                  rsp_valid;
   logic signed [31:0]    rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic                  csr_ready;

   int fail_count;
   int outstanding;
   int hold_seq  = 0;
   int burst_left = 0;

   matrix4_vector_transform #(.ROW_DOT(ROW_DOT_SEL), .FRAC_BITS(FRAC_SEL)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_vec_x(req_vec_x), .req_vec_y(req_vec_y),
      .req_vec_z(req_vec_z), .req_vec_w(req_vec_w),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z), .rsp_out_w(rsp_out_w),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   mvt_checker #(.ROW_DOT(ROW_DOT_SEL), .FRAC_BITS(FRAC_SEL)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_vec_x(req_vec_x), .req_vec_y(req_vec_y),
      .req_vec_z(req_vec_z), .req_vec_w(req_vec_w),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z), .rsp_out_w(rsp_out_w),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("matrix4_vector_transform verification failed");
      $finish;
   end

   function automatic mvt_pkg::elem_type rand_elem(input fill_mode_type mode);
      fill_mode_type pick;
      pick = mode;
      if (mode == FILL_MIXED)
         pick = fill_mode_type'($urandom_range(FILL_FULL, FILL_EDGE));
      case (pick)
         FILL_SMALL: return mvt_pkg::elem_type'(int'($urandom_range(0, 524288)) - 262144);
         FILL_EDGE: begin
            case ($urandom_range(0, 7))
               0: return ELEM_MIN;
               1: return ELEM_MAX;
               2: return '0;
               3: return -1;
               4: return 1;
               5: return ONE;
               6: return -ONE;
               default: return ELEM_MIN + 1;
            endcase
         end
         default: return mvt_pkg::elem_type'($urandom);
      endcase
   endfunction

   function automatic mvt_pkg::mat_type make_matrix(input fill_mode_type mode);
      mvt_pkg::mat_type m;
      int r, c;
      for (r = 0; r < 4; r++)
         for (c = 0; c < 4; c++)
            case (mode)
               FILL_IDENT: m[r][c] = (r == c) ? ONE : '0;
               FILL_ZERO:  m[r][c] = '0;
               default:    m[r][c] = rand_elem(mode);
            endcase
      return m;
   endfunction

   task automatic write_reg(input logic [mvt_pkg::REG_IDX_W-1:0] idx,
                            input logic [mvt_pkg::REG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // two elements per register, low half holds the even column
   task automatic set_matrix(input mvt_pkg::mat_type m);
      int i;
      for (i = 0; i < mvt_pkg::NUM_REGS; i++)
         write_reg(IW'(i), {m[i / 2][(i % 2) * 2 + 1], m[i / 2][(i % 2) * 2]});
      csr_valid <= 1'b0;
   endtask

   task automatic send_vec(input mvt_pkg::elem_type x, input mvt_pkg::elem_type y,
                           input mvt_pkg::elem_type z, input mvt_pkg::elem_type w);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_vec_x <= x;
      req_vec_y <= y;
      req_vec_z <= z;
      req_vec_w <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // receiver: random segments of flow patterns, plus a long hold on request
   initial begin : rsp_side
      int seg_left, seg_mode, seen_seq, k;
      seg_left = 0;
      seg_mode = 0;
      seen_seq = 0;
      forever begin
         @(posedge clock);
         if (hold_seq != seen_seq) begin
            seen_seq = hold_seq;
            rsp_ready <= 1'b0;
            for (k = 0; k < LONG_HOLD; k++) @(posedge clock);
         end
         if (seg_left == 0) begin
            seg_mode = $urandom_range(0, 3);
            seg_left = $urandom_range(4, 40);
         end
         seg_left--;
         case (seg_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= seg_left[0];
         endcase
      end
   end

   initial begin : stimulus
      mvt_pkg::mat_type m;
      fill_mode_type    phase_fill[7];
      fill_mode_type    vmode;
      int ph, n, r, c, sel;

      phase_fill = '{FILL_FULL, FILL_SMALL, FILL_EDGE, FILL_MIXED,
                     FILL_IDENT, FILL_ZERO, FILL_SMALL};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity after reset
      send_vec(0, 0, 0, 0);
      send_vec(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
      send_vec(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
      send_vec(ELEM_MIN, ELEM_MAX, -1, 1);
      send_vec(ONE, -ONE, 1, -1);
      wait_idle();

      // writes past the last register must leave the matrix alone
      write_reg(IW'(8), '1);
      write_reg(IW'(15), 64'h5555_AAAA_1234_8765);
      csr_valid <= 1'b0;
      send_vec(123456, -7, ELEM_MIN, ELEM_MAX);
      wait_idle();

      // half on the diagonal: negative odd inputs round toward minus infinity
      m = make_matrix(FILL_ZERO);
      for (r = 0; r < 4; r++) m[r][r] = ONE / 2;
      set_matrix(m);
      send_vec(-1, 1, -3, 3);
      send_vec(ELEM_MIN, ELEM_MIN, ELEM_MAX, ELEM_MAX);
      wait_idle();

      // most negative everywhere: saturate both ways
      m = make_matrix(FILL_ZERO);
      for (r = 0; r < 4; r++) for (c = 0; c < 4; c++) m[r][c] = ELEM_MIN;
      set_matrix(m);
      send_vec(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
      send_vec(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
      send_vec(1, 1, 1, 1);
      send_vec(-1, -1, -1, -1);
      wait_idle();

      m = make_matrix(FILL_ZERO);
      for (r = 0; r < 4; r++) for (c = 0; c < 4; c++) m[r][c] = ELEM_MAX;
      set_matrix(m);
      send_vec(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
      send_vec(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
      send_vec(0, 0, 0, 1);
      wait_idle();

      // distinct elements tell rows from columns
      for (r = 0; r < 4; r++)
         for (c = 0; c < 4; c++)
            m[r][c] = mvt_pkg::elem_type'((r * 4 + c + 1) << FRAC_SEL);
      set_matrix(m);
      send_vec(ONE, 2 * ONE, 3 * ONE, 4 * ONE);
      send_vec(0, 0, 0, ONE);
      wait_idle();

      for (ph = 0; ph < 7; ph++) begin
         set_matrix(make_matrix(phase_fill[ph]));
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == 10 && (ph == 0 || ph == 3))
               hold_seq <= hold_seq + 1;
            sel = $urandom_range(0, 99);
            if (sel < 40)      vmode = FILL_FULL;
            else if (sel < 70) vmode = FILL_SMALL;
            else if (sel < 85) vmode = FILL_EDGE;
            else               vmode = FILL_MIXED;
            send_vec(rand_elem(vmode), rand_elem(vmode), rand_elem(vmode), rand_elem(vmode));
         end
         wait_idle();
      end

      repeat (12) @(posedge clock);
      if (fail_count == 0)
         $display("matrix4_vector_transform verification clean");
      else
         $display("matrix4_vector_transform verification failed");
      $finish;
   end

endmodule
